// ----- rtl/gla_pkg.sv -----
// Shared constants, types and helpers for the geodetic look-angle pipeline.
package gla_pkg;

   localparam int TRIG_W     = 32;
   localparam int ALT_W      = 25;
   localparam int CRD_W      = 34;
   localparam int VEC_W      = 54;
   localparam int POS_W      = 34;
   localparam int SQRT_W     = 63;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_BITS   = 31;
   localparam int DIV_START  = 4 + SQRT_STEPS + 1 + DIV_BITS;
   localparam int ECEF_LAT   = DIV_START + 6;

   localparam logic signed [CRD_W-1:0] K_Q30   = 34'sd652032874;
   localparam logic signed [31:0]      G_Q30   = 32'sd1768195363;
   localparam logic [22:0]             E2_Q30  = 23'd7188036;
   localparam logic [29:0]             A_CM    = 30'd637813700;
   localparam logic signed [ALT_W-1:0] ALT_MIN = -25'sd100000;
   localparam logic signed [ALT_W-1:0] ALT_MAX = 25'sd10000000;
   localparam logic signed [31:0]      QUARTER = 32'sh4000_0000;

   typedef struct packed {
      logic signed [TRIG_W-1:0] clat;
      logic signed [TRIG_W-1:0] slat;
      logic signed [TRIG_W-1:0] clon;
      logic signed [TRIG_W-1:0] slon;
   } gla_trig_type;

   typedef struct packed {
      gla_trig_type             trig;
      logic signed [ALT_W-1:0]  alt;
   } gla_pos_type;

   // Arctangent of 2^-i as a binary angle, 2^32 per turn.
   function automatic logic [31:0] gla_atan(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

   // Round a Q30 product: add one half, shift right by 30 with floor.
   function automatic logic signed [71:0] gla_rq30(input logic signed [71:0] p);
      logic signed [71:0] sum;
      sum = p + 72'sd536870912;
      return sum >>> 30;
   endfunction

endpackage

// ----- rtl/gla_delay.sv -----
// Register chain that delays a bundle of payload bits, advancing while en is high.
module gla_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] pipe_ff [DEPTH];

   // advance the chain on every enabled cycle
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];
endmodule

// ----- rtl/gla_cordic_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
module gla_cordic_cell #(
   parameter int XW     = 34,
   parameter int ZW     = 34,
   parameter int IDX    = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] src_x,
   input  logic signed [XW-1:0] src_y,
   input  logic [ZW-1:0]        src_z,
   output logic signed [XW-1:0] dst_x,
   output logic signed [XW-1:0] dst_y,
   output logic [ZW-1:0]        dst_z
);
   import gla_pkg::*;

   localparam logic [ZW-1:0] ATAN = ZW'(gla_atan(IDX));

   logic signed [XW-1:0] dx, dy;
   logic                 cw;
   logic signed [XW-1:0] x_ff, y_ff;
   logic [ZW-1:0]        z_ff;

   assign dx = src_y >>> IDX;
   assign dy = src_x >>> IDX;
   // rotate toward z = 0, or toward y = 0 when vectoring
   assign cw = VECTOR ? src_y[XW-1] : ~src_z[ZW-1];

   always_ff @(posedge clock) begin
      if (en) begin
         if (cw) begin
            x_ff <= src_x - dx;
            y_ff <= src_y + dy;
            z_ff <= src_z - ATAN;
         end else begin
            x_ff <= src_x + dx;
            y_ff <= src_y - dy;
            z_ff <= src_z + ATAN;
         end
      end
   end

   assign dst_x = x_ff;
   assign dst_y = y_ff;
   assign dst_z = z_ff;
endmodule

// ----- rtl/gla_sqrt_cell.sv -----
// One bit-pair step of the integer square root, registered.
module gla_sqrt_cell #(
   parameter int W     = 63,
   parameter int SHIFT = 62
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] src_v,
   input  logic [W-1:0] src_r,
   output logic [W-1:0] dst_v,
   output logic [W-1:0] dst_r
);
   localparam logic [W-1:0] B = W'(1) << SHIFT;

   logic [W-1:0] rb;
   logic         take;
   logic [W-1:0] v_ff, r_ff;

   assign rb   = src_r + B;
   assign take = src_v >= rb;

   // subtract the trial value where it fits and set the result bit
   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= take ? src_v - rb : src_v;
         r_ff <= take ? (src_r >> 1) + B : src_r >> 1;
      end
   end

   assign dst_v = v_ff;
   assign dst_r = r_ff;
endmodule

// ----- rtl/gla_div_cell.sv -----
// One quotient bit of a restoring divider, registered.
module gla_div_cell #(
   parameter int RW = 63,
   parameter int DW = 31,
   parameter int J  = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] src_rem,
   input  logic [DW-1:0] src_d,
   input  logic [DW-1:0] src_q,
   output logic [RW-1:0] dst_rem,
   output logic [DW-1:0] dst_d,
   output logic [DW-1:0] dst_q
);
   logic [RW-1:0] trial;
   logic          take;
   logic [DW-1:0] q_in;
   logic [RW-1:0] rem_ff;
   logic [DW-1:0] d_ff, q_ff;

   assign trial = RW'(src_d) << J;
   assign take  = src_rem >= trial;

   always_comb begin
      q_in    = src_q;
      q_in[J] = take;
   end

   // subtract the shifted divisor where it fits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= take ? src_rem - trial : src_rem;
         d_ff   <= src_d;
         q_ff   <= q_in;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_d   = d_ff;
   assign dst_q   = q_ff;
endmodule

// ----- rtl/gla_ecef.sv -----
// Geodetic to earth-centred conversion on the WGS84 ellipsoid, pipelined.
module gla_ecef (
   input  logic                             clock,
   input  logic                             en,
   input  gla_pkg::gla_pos_type             pos,
   output logic signed [gla_pkg::POS_W-1:0] x,
   output logic signed [gla_pkg::POS_W-1:0] y,
   output logic signed [gla_pkg::POS_W-1:0] z
);
   import gla_pkg::*;

   logic signed [63:0]  sq_prod;
   logic [63:0]         sq_ff;
   logic [33:0]         s2_ff;
   logic [56:0]         e2p_ff;
   logic [30:0]         w_ff;
   logic [SQRT_W-1:0]   sv [SQRT_STEPS+1];
   logic [SQRT_W-1:0]   sr [SQRT_STEPS+1];
   logic [SQRT_W-1:0]   root;
   logic [SQRT_W-1:0]   div_num_ff;
   logic [DIV_BITS-1:0] div_d_ff;
   logic [SQRT_W-1:0]   drem [DIV_BITS+1];
   logic [DIV_BITS-1:0] dd [DIV_BITS+1];
   logic [DIV_BITS-1:0] dq [DIV_BITS+1];
   logic [$bits(gla_pos_type)-1:0] pos_bits;
   gla_pos_type         b0, b1_ff, b2_ff, b3_ff, b4_ff;
   logic signed [31:0]  n1_ff;
   logic signed [55:0]  nm_ff;
   logic signed [32:0]  nz_ff, na_ff;
   logic signed [64:0]  tp_ff;
   logic signed [33:0]  nza_ff;
   logic signed [35:0]  t_ff;
   logic signed [65:0]  zp_ff;
   logic signed [67:0]  xp_ff, yp_ff;
   logic signed [POS_W-1:0] z5_ff, x_ff, y_ff, z_ff;

   // sin^2 of latitude, scaled by e^2, gives the radius term w
   assign sq_prod = pos.trig.slat * pos.trig.slat;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= unsigned'(sq_prod);
         s2_ff  <= 34'((sq_ff + 64'd536870912) >> 30);
         e2p_ff <= 57'(s2_ff) * 57'(E2_Q30);
         w_ff   <= 31'h4000_0000 - 31'((e2p_ff + 57'd536870912) >> 30);
      end
   end

   // floor(sqrt(w * 2^30)), one bit pair per cell
   assign sv[0] = SQRT_W'(w_ff) << 30;
   assign sr[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      gla_sqrt_cell #(.W(SQRT_W), .SHIFT(2 * (SQRT_STEPS - 1 - k))) u_cell (
         .clock (clock),
         .en    (en),
         .src_v (sv[k]),
         .src_r (sr[k]),
         .dst_v (sv[k+1]),
         .dst_r (sr[k+1])
      );
   end

   // prime divider: N = round(a * 2^30 / root)
   assign root = (sr[SQRT_STEPS] == '0) ? SQRT_W'(1) : sr[SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         div_num_ff <= (SQRT_W'(A_CM) << 30) + (root >> 1);
         div_d_ff   <= root[DIV_BITS-1:0];
      end
   end

   assign drem[0] = div_num_ff;
   assign dd[0]   = div_d_ff;
   assign dq[0]   = '0;

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      gla_div_cell #(.RW(SQRT_W), .DW(DIV_BITS), .J(DIV_BITS - 1 - k)) u_cell (
         .clock   (clock),
         .en      (en),
         .src_rem (drem[k]),
         .src_d   (dd[k]),
         .src_q   (dq[k]),
         .dst_rem (drem[k+1]),
         .dst_d   (dd[k+1]),
         .dst_q   (dq[k+1])
      );
   end

   // carry trig and altitude alongside the radius computation
   gla_delay #(.W($bits(gla_pos_type)), .DEPTH(DIV_START)) u_pos_dly (
      .clock (clock),
      .en    (en),
      .din   (pos),
      .dout  (pos_bits)
   );
   assign b0 = gla_pos_type'(pos_bits);

   // scale by N and the trig terms into x, y, z
   always_ff @(posedge clock) begin
      if (en) begin
         b1_ff  <= b0;
         b2_ff  <= b1_ff;
         b3_ff  <= b2_ff;
         b4_ff  <= b3_ff;
         n1_ff  <= signed'({1'b0, dq[DIV_BITS]});
         nm_ff  <= signed'({1'b0, dq[DIV_BITS]}) * signed'({1'b0, E2_Q30});
         nz_ff  <= 33'(n1_ff) - 33'(gla_rq30(72'(nm_ff)));
         na_ff  <= 33'(n1_ff) + 33'(b1_ff.alt);
         tp_ff  <= na_ff * b2_ff.trig.clat;
         nza_ff <= 34'(nz_ff) + 34'(b2_ff.alt);
         t_ff   <= 36'(gla_rq30(72'(tp_ff)));
         zp_ff  <= nza_ff * b3_ff.trig.slat;
         xp_ff  <= t_ff * b4_ff.trig.clon;
         yp_ff  <= t_ff * b4_ff.trig.slon;
         z5_ff  <= POS_W'(gla_rq30(72'(zp_ff)));
         x_ff   <= POS_W'(gla_rq30(72'(xp_ff)));
         y_ff   <= POS_W'(gla_rq30(72'(yp_ff)));
         z_ff   <= z5_ff;
      end
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
endmodule

// ----- rtl/geodetic_look_angle_top.sv -----
// Top level: look angles from observer to target on the WGS84 ellipsoid.
//
// Request channel (req_*): observer and target latitude, longitude (32-bit
// binary angles, 2^32 per turn) and altitude (25-bit centimetres, saturated
// to -100000..10000000). A beat is taken when req_valid is high and
// req_stall is low. Response channel (rsp_*): azimuth clockwise from north
// (unsigned) and elevation (signed), rounded to ANGLE_BITS and presented in
// 24-bit fields; a beat leaves when rsp_valid is high and rsp_stall is low.
// Every request yields exactly one response, in order.
// The path runs through three chains of CORDIC cells (sine/cosine, azimuth,
// elevation), a 32-cell square root, a 31-cell divider and multiply stages.
// One beat per cycle is accepted while the output is not stalled; the
// pipeline is a row of registered cells that all advance together.
// While the response register holds a beat and rsp_stall is high, the whole
// pipeline holds and req_stall is raised; no beat is lost or repeated.
// Reset clears the valid bits only; the pipeline comes out empty.
module geodetic_look_angle_top #(
   parameter int ANGLE_BITS        = 24,
   parameter int CORDIC_ITERATIONS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_observer_lat,
   input  logic signed [31:0] req_observer_lon,
   input  logic signed [24:0] req_observer_alt,
   input  logic signed [31:0] req_target_lat,
   input  logic signed [31:0] req_target_lon,
   input  logic signed [24:0] req_target_alt,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_azimuth,
   output logic signed [23:0] rsp_elevation
);
   import gla_pkg::*;

   localparam int C      = CORDIC_ITERATIONS;
   localparam int LAT    = 3 * C + 10 + ECEF_LAT;
   localparam int AZ_OUT = 2 * C + ECEF_LAT + 7;
   localparam int SH     = 32 - ANGLE_BITS;
   localparam logic signed [33:0] HALF  = 34'((64'd1 << SH) >> 1);
   localparam logic [33:0]        AMASK = 34'((64'd1 << ANGLE_BITS) - 64'd1);

   logic             en;
   logic [LAT-1:0]   vld_ff;

   logic signed [31:0]      olat_ff, olon_ff, tlat_ff, tlon_ff;
   logic signed [ALT_W-1:0] oalt_ff, talt_ff, oalt_sat, talt_sat;
   logic [31:0]             ang [4];
   logic [3:0]              flip;
   logic signed [CRD_W-1:0] scx [4][C+1];
   logic signed [CRD_W-1:0] scy [4][C+1];
   logic [CRD_W-1:0]        scz [4][C+1];
   logic [3+2*ALT_W:0]      sc_side, sc_side_d;
   logic [3:0]              flip_d;
   logic signed [ALT_W-1:0] oalt_d, talt_d;
   logic signed [TRIG_W-1:0] tc [4];
   logic signed [TRIG_W-1:0] ts [4];
   gla_pos_type             opos_ff, tpos_ff;

   logic signed [POS_W-1:0] ox, oy, oz, tx, ty, tz;
   logic [$bits(gla_trig_type)-1:0] otrig_bits;
   gla_trig_type            otrig_d, tr1_ff, tr2_ff, tr3_ff;
   logic signed [34:0]      vx1_ff, vy1_ff, vz1_ff, vz2_ff, vz3_ff;
   logic signed [67:0]      m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [67:0]      m5_ff, m6_ff, m7_ff, m8_ff;
   logic signed [35:0]      p3_ff, east3_ff, east4_ff, east5_ff, north5_ff, up5_ff;
   logic signed [VEC_W-1:0] nx, ny;
   logic signed [VEC_W-1:0] xa6_ff, ya6_ff;
   logic [31:0]             z06_ff;
   logic                    zero6_ff, upp6_ff, upn6_ff;
   logic signed [67:0]      upg6_ff;
   logic signed [VEC_W-1:0] ye;

   logic signed [VEC_W-1:0] ax [C+1];
   logic signed [VEC_W-1:0] ay [C+1];
   logic [31:0]             az [C+1];
   logic [VEC_W+2:0]        az_side, az_side_d;
   logic signed [VEC_W-1:0] ye_d, mag;
   logic                    zero_d, upp_d, upn_d;

   logic signed [VEC_W-1:0] ex7_ff, ey7_ff;
   logic [31:0]             azf7_ff;
   logic                    spec7_ff, upp7_ff, upn7_ff;
   logic signed [VEC_W-1:0] ex [C+1];
   logic signed [VEC_W-1:0] ey [C+1];
   logic [31:0]             ez [C+1];
   logic [34:0]             el_side, el_side_d;
   logic                    spec_d, uppe_d, upne_d;
   logic [31:0]             azf_d, el_val;
   logic signed [33:0]      az_q, el_q;
   logic [33:0]             az_m, el_m;
   logic [23:0]             azimuth_ff;
   logic signed [23:0]      elevation_ff;

   // hold everything while a finished beat waits at the output
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (en) begin
         olat_ff <= req_observer_lat;
         olon_ff <= req_observer_lon;
         oalt_ff <= req_observer_alt;
         tlat_ff <= req_target_lat;
         tlon_ff <= req_target_lon;
         talt_ff <= req_target_alt;
      end
   end

   // clamp altitudes
   assign oalt_sat = (oalt_ff < ALT_MIN) ? ALT_MIN : (oalt_ff > ALT_MAX) ? ALT_MAX : oalt_ff;
   assign talt_sat = (talt_ff < ALT_MIN) ? ALT_MIN : (talt_ff > ALT_MAX) ? ALT_MAX : talt_ff;

   assign ang[0] = olat_ff;
   assign ang[1] = olon_ff;
   assign ang[2] = tlat_ff;
   assign ang[3] = tlon_ff;

   // four sine/cosine lanes, each folded into the right half-plane first
   for (genvar ln = 0; ln < 4; ln++) begin : g_lane
      logic [31:0] u_sum, u_fold;
      assign u_sum       = ang[ln] + 32'h4000_0000;
      assign flip[ln]    = u_sum[31];
      assign u_fold      = flip[ln] ? ang[ln] + 32'h8000_0000 : ang[ln];
      assign scx[ln][0]  = K_Q30;
      assign scy[ln][0]  = '0;
      assign scz[ln][0]  = CRD_W'(signed'(u_fold));

      for (genvar k = 0; k < C; k++) begin : g_cell
         gla_cordic_cell #(.XW(CRD_W), .ZW(CRD_W), .IDX(k), .VECTOR(1'b0)) u_cell (
            .clock (clock),
            .en    (en),
            .src_x (scx[ln][k]),
            .src_y (scy[ln][k]),
            .src_z (scz[ln][k]),
            .dst_x (scx[ln][k+1]),
            .dst_y (scy[ln][k+1]),
            .dst_z (scz[ln][k+1])
         );
      end

      assign tc[ln] = TRIG_W'(flip_d[ln] ? -scx[ln][C] : scx[ln][C]);
      assign ts[ln] = TRIG_W'(flip_d[ln] ? -scy[ln][C] : scy[ln][C]);
   end

   assign sc_side = {flip, oalt_sat, talt_sat};

   gla_delay #(.W(4 + 2 * ALT_W), .DEPTH(C)) u_sc_dly (
      .clock (clock),
      .en    (en),
      .din   (sc_side),
      .dout  (sc_side_d)
   );
   assign {flip_d, oalt_d, talt_d} = sc_side_d;

   // undo the fold and bundle trig with altitude per position
   always_ff @(posedge clock) begin
      if (en) begin
         opos_ff <= '{trig: '{clat: tc[0], slat: ts[0], clon: tc[1], slon: ts[1]},
                      alt: oalt_d};
         tpos_ff <= '{trig: '{clat: tc[2], slat: ts[2], clon: tc[3], slon: ts[3]},
                      alt: talt_d};
      end
   end

   gla_ecef u_obs_ecef (
      .clock (clock),
      .en    (en),
      .pos   (opos_ff),
      .x     (ox),
      .y     (oy),
      .z     (oz)
   );

   gla_ecef u_tgt_ecef (
      .clock (clock),
      .en    (en),
      .pos   (tpos_ff),
      .x     (tx),
      .y     (ty),
      .z     (tz)
   );

   gla_delay #(.W($bits(gla_trig_type)), .DEPTH(ECEF_LAT)) u_trig_dly (
      .clock (clock),
      .en    (en),
      .din   (opos_ff.trig),
      .dout  (otrig_bits)
   );
   assign otrig_d = gla_trig_type'(otrig_bits);

   // rotate the difference vector into east, north, up
   always_ff @(posedge clock) begin
      if (en) begin
         vx1_ff    <= 35'(tx) - 35'(ox);
         vy1_ff    <= 35'(ty) - 35'(oy);
         vz1_ff    <= 35'(tz) - 35'(oz);
         tr1_ff    <= otrig_d;
         m1_ff     <= tr1_ff.clon * vx1_ff;
         m2_ff     <= tr1_ff.slon * vy1_ff;
         m3_ff     <= tr1_ff.clon * vy1_ff;
         m4_ff     <= tr1_ff.slon * vx1_ff;
         vz2_ff    <= vz1_ff;
         tr2_ff    <= tr1_ff;
         p3_ff     <= 36'(gla_rq30(72'(m1_ff) + 72'(m2_ff)));
         east3_ff  <= 36'(gla_rq30(72'(m3_ff) - 72'(m4_ff)));
         vz3_ff    <= vz2_ff;
         tr3_ff    <= tr2_ff;
         m5_ff     <= tr3_ff.clat * vz3_ff;
         m6_ff     <= tr3_ff.slat * p3_ff;
         m7_ff     <= tr3_ff.clat * p3_ff;
         m8_ff     <= tr3_ff.slat * vz3_ff;
         east4_ff  <= east3_ff;
         north5_ff <= 36'(gla_rq30(72'(m5_ff) - 72'(m6_ff)));
         up5_ff    <= 36'(gla_rq30(72'(m7_ff) + 72'(m8_ff)));
         east5_ff  <= east4_ff;
      end
   end

   // azimuth seed: scale by 2^16, fold to north >= 0 with a half-turn start
   assign nx = VEC_W'(north5_ff) <<< 16;
   assign ny = VEC_W'(east5_ff) <<< 16;

   always_ff @(posedge clock) begin
      if (en) begin
         xa6_ff   <= north5_ff[35] ? -nx : nx;
         ya6_ff   <= north5_ff[35] ? -ny : ny;
         z06_ff   <= north5_ff[35] ? 32'h8000_0000 : 32'h0;
         zero6_ff <= (north5_ff == '0) && (east5_ff == '0);
         upp6_ff  <= !up5_ff[35] && (up5_ff != '0);
         upn6_ff  <= up5_ff[35];
         upg6_ff  <= up5_ff * G_Q30;
      end
   end

   assign ye = VEC_W'((72'(upg6_ff) + 72'sd8192) >>> 14);

   assign ax[0] = xa6_ff;
   assign ay[0] = ya6_ff;
   assign az[0] = z06_ff;

   for (genvar k = 0; k < C; k++) begin : g_az
      gla_cordic_cell #(.XW(VEC_W), .ZW(32), .IDX(k), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .en    (en),
         .src_x (ax[k]),
         .src_y (ay[k]),
         .src_z (az[k]),
         .dst_x (ax[k+1]),
         .dst_y (ay[k+1]),
         .dst_z (az[k+1])
      );
   end

   assign az_side = {ye, zero6_ff, upp6_ff, upn6_ff};

   gla_delay #(.W(VEC_W + 3), .DEPTH(C)) u_az_dly (
      .clock (clock),
      .en    (en),
      .din   (az_side),
      .dout  (az_side_d)
   );
   assign {ye_d, zero_d, upp_d, upn_d} = az_side_d;
   assign mag = ax[C];

   // elevation seed: magnitude against scaled up; straight up or down is special
   always_ff @(posedge clock) begin
      if (en) begin
         ex7_ff   <= mag;
         ey7_ff   <= ye_d;
         azf7_ff  <= zero_d ? 32'h0 : az[C];
         spec7_ff <= zero_d || mag[VEC_W-1] || (mag == '0);
         upp7_ff  <= upp_d;
         upn7_ff  <= upn_d;
      end
   end

   assign ex[0] = ex7_ff;
   assign ey[0] = ey7_ff;
   assign ez[0] = '0;

   for (genvar k = 0; k < C; k++) begin : g_el
      gla_cordic_cell #(.XW(VEC_W), .ZW(32), .IDX(k), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .en    (en),
         .src_x (ex[k]),
         .src_y (ey[k]),
         .src_z (ez[k]),
         .dst_x (ex[k+1]),
         .dst_y (ey[k+1]),
         .dst_z (ez[k+1])
      );
   end

   assign el_side = {spec7_ff, upp7_ff, upn7_ff, azf7_ff};

   gla_delay #(.W(35), .DEPTH(C)) u_el_dly (
      .clock (clock),
      .en    (en),
      .din   (el_side),
      .dout  (el_side_d)
   );
   assign {spec_d, uppe_d, upne_d, azf_d} = el_side_d;

   // pick the elevation and round both angles to the output step
   assign el_val = !spec_d ? ez[C] : uppe_d ? QUARTER : upne_d ? -QUARTER : 32'h0;
   assign az_q   = (signed'({2'b00, azf_d}) + HALF) >>> SH;
   assign el_q   = (34'(signed'(el_val)) + HALF) >>> SH;
   assign az_m   = az_q & AMASK;
   assign el_m   = el_q & AMASK;

   always_ff @(posedge clock) begin
      if (en) begin
         azimuth_ff   <= az_m[23:0];
         elevation_ff <= el_m[23:0];
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_azimuth   = azimuth_ff;
   assign rsp_elevation = elevation_ff;

`ifndef SYNTHESIS
   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipeline moved while the output beat was held");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request beat did not enter the pipeline");

   a_mag_positive: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[AZ_OUT] && !zero_d) |-> (!mag[VEC_W-1] && (mag != '0)))
      else $error("horizontal magnitude not positive for a nonzero east/north");

   a_elev_mag_positive: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-2] && !spec_d) |-> !ex[C][VEC_W-1])
      else $error("elevation magnitude went negative");
`endif
endmodule
